// ----- hdl/cpli_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpli_pkg
// Shared types, widths and helpers for the clamped piecewise linear
// interpolation table.
// ----------------------------------------------------------------------------
package cpli_pkg;

    localparam int TABLE_POINTS = 32;
    localparam int PT_W         = $clog2(TABLE_POINTS);
    localparam int NUM_W        = $clog2(TABLE_POINTS + 1);
    localparam int STRAIN_W     = 32;
    localparam int VALUE_W      = 24;
    localparam int CFG_W        = 6;
    localparam int IDX_W        = 5;
    localparam int PROD_W       = STRAIN_W + VALUE_W;
    localparam int DIV_CNT_W    = $clog2(VALUE_W + 1);

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REGION_INTERP = 2'd0,
        REGION_BELOW  = 2'd1,
        REGION_ABOVE  = 2'd2,
        REGION_SINGLE = 2'd3
    } region_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_SEG,
        ST_MUL,
        ST_ADJ,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [STRAIN_W-1:0] strain;
        logic [VALUE_W-1:0]  value;
    } entry_t;

    typedef struct packed {
        logic            we;
        logic [PT_W-1:0] waddr;
        entry_t          wdata;
        logic [PT_W-1:0] raddr;
    } mem_req_t;

    function automatic logic [NUM_W-1:0] used_points(input logic [CFG_W-1:0] c);
        if (c == '0) begin
            return NUM_W'(1);
        end
        if (int'(c) > TABLE_POINTS) begin
            return NUM_W'(TABLE_POINTS);
        end
        return NUM_W'(c);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/cpli_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpli_mem
// Breakpoint table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cpli_mem
    import cpli_pkg::*;
(
    input  wire logic     aclk,
    input  wire mem_req_t req,
    output entry_t        rd_data
);

    entry_t mem [TABLE_POINTS];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- hdl/cpli_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpli_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in VALUE_W bits (numerator below divisor times 2^VALUE_W).
// ----------------------------------------------------------------------------
module cpli_div
    import cpli_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [PROD_W-1:0]   num,
    input  wire logic [STRAIN_W-1:0] den,
    output logic                     done,
    output logic [VALUE_W-1:0]       quot
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [STRAIN_W-1:0]  rem_reg, rem_next;
    logic [VALUE_W-1:0]   low_reg, low_next;
    logic [STRAIN_W-1:0]  den_reg, den_next;
    logic [STRAIN_W:0]    trial;
    logic                 ge;

    always_comb begin
        trial     = {rem_reg, low_reg[VALUE_W-1]};
        ge        = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(VALUE_W);
            rem_next  = num[PROD_W-1:VALUE_W];
            low_next  = num[VALUE_W-1:0];
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = ge ? STRAIN_W'(trial - {1'b0, den_reg}) : trial[STRAIN_W-1:0];
            low_next = {low_reg[VALUE_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = low_reg;

`ifndef SYNTH
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !$past(start) |-> rem_reg < den_reg)
        else $error("partial remainder not below divisor");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished division");
`endif

endmodule
`default_nettype wire

// ----- hdl/clamped_piecewise_linear_interp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clamped_piecewise_linear_interp
// Breakpoint table with clamped linear interpolation between entries.
//
// Input channel s_*: a load beat (s_mode = load) writes one (strain, value)
// breakpoint at s_point_index and yields no result. A query beat evaluates
// the table at s_query_strain and yields one result beat on m_* (value and
// region code). cfg_wr_en/cfg_wr_data set the number of points in use (0
// acts as 1, values above 32 act as 32).
// A query reads the first and last entries, then scans one entry per cycle
// until the bracketing interval is found (up to n-1 reads), then runs one
// multiply and a 24-step bit-serial division. A clamped or single-point
// query goes to done after the last-entry read, a flat segment after the
// segment state. One query is in flight at a time; the next beat is taken
// only in idle, after the previous result is registered.
// While a result waits for the receiver the block keeps accepting; a second
// finished result holds until the first is taken, stalling the input.
// Reset clears control state and sets points in use to 1; table contents
// are undefined until loaded.
// ----------------------------------------------------------------------------
module clamped_piecewise_linear_interp
    import cpli_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_W-1:0]    cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_mode,
    input  wire logic [IDX_W-1:0]    s_point_index,
    input  wire logic [STRAIN_W-1:0] s_point_strain,
    input  wire logic [VALUE_W-1:0]  s_point_value,
    input  wire logic [STRAIN_W-1:0] s_query_strain,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [VALUE_W-1:0]       m_value,
    output logic [1:0]               m_region
);

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    cfg_reg;
    logic [STRAIN_W-1:0] x_reg;
    logic [NUM_W-1:0]    n_reg;
    logic [PT_W-1:0]     k_reg;
    entry_t              lo_reg, hi_reg;
    logic [STRAIN_W-1:0] t_reg, dx_reg;
    logic [VALUE_W-1:0]  mag_reg;
    logic                fall_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [VALUE_W-1:0]  res_value_reg;
    region_t             res_region_reg;
    logic                m_valid_reg;
    logic [VALUE_W-1:0]  m_value_reg;
    region_t             m_region_reg;

    mem_req_t            mem_req;
    entry_t              rd_data;
    logic                div_start, div_done;
    logic [PROD_W-1:0]   div_num;
    logic [VALUE_W-1:0]  div_quot;

    logic                accept, out_free, scan_hit, seg_flat;
    logic [PT_W-1:0]     last_idx;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_idx = PT_W'(n_reg - NUM_W'(1));
    assign scan_hit = (x_reg <= rd_data.strain) || (k_reg == last_idx);
    assign seg_flat = (hi_reg.strain <= lo_reg.strain) || (x_reg <= lo_reg.strain);
    assign div_num  = prod_reg + (fall_reg ? PROD_W'(dx_reg - 1'b1) : PROD_W'(0));

    cpli_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    cpli_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (dx_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_mode == MODE_QUERY) begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST: state_next = ST_LAST;
            ST_LAST: begin
                if (x_reg < lo_reg.strain || x_reg > rd_data.strain || n_reg == NUM_W'(1)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG:  state_next = seg_flat ? ST_DONE : ST_MUL;
            ST_MUL:  state_next = ST_ADJ;
            ST_ADJ:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready       = 1'b0;
        div_start     = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = PT_W'(s_point_index);
        mem_req.wdata = '{strain: s_point_strain, value: s_point_value};
        mem_req.raddr = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                mem_req.we = s_valid && s_mode == MODE_LOAD
                             && int'(s_point_index) < TABLE_POINTS;
            end
            ST_FIRST: mem_req.raddr = last_idx;
            ST_LAST:  mem_req.raddr = PT_W'(1);
            ST_SCAN:  mem_req.raddr = PT_W'(k_reg + 1'b1);
            ST_ADJ:   div_start = 1'b1;
            ST_SEG, ST_MUL, ST_DIV, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= CFG_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_value_reg  <= res_value_reg;
            m_region_reg <= res_region_reg;
        end
        case (state_reg)
            ST_IDLE: begin
                x_reg <= s_query_strain;
                n_reg <= used_points(cfg_reg);
            end
            ST_FIRST: begin
                lo_reg <= rd_data;
            end
            ST_LAST: begin
                k_reg <= PT_W'(1);
                if (x_reg < lo_reg.strain) begin
                    res_value_reg  <= lo_reg.value;
                    res_region_reg <= REGION_BELOW;
                end else if (x_reg > rd_data.strain) begin
                    res_value_reg  <= rd_data.value;
                    res_region_reg <= REGION_ABOVE;
                end else begin
                    res_value_reg  <= lo_reg.value;
                    res_region_reg <= REGION_SINGLE;
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    hi_reg <= rd_data;
                end else begin
                    lo_reg <= rd_data;
                    k_reg  <= PT_W'(k_reg + 1'b1);
                end
            end
            ST_SEG: begin
                res_value_reg  <= lo_reg.value;
                res_region_reg <= REGION_INTERP;
                t_reg          <= x_reg - lo_reg.strain;
                dx_reg         <= hi_reg.strain - lo_reg.strain;
                fall_reg       <= hi_reg.value < lo_reg.value;
                mag_reg        <= (hi_reg.value < lo_reg.value)
                                  ? lo_reg.value - hi_reg.value
                                  : hi_reg.value - lo_reg.value;
            end
            ST_MUL: begin
                prod_reg <= PROD_W'(t_reg) * PROD_W'(mag_reg);
            end
            ST_DIV: begin
                if (div_done) begin
                    res_value_reg <= fall_reg ? lo_reg.value - div_quot
                                              : lo_reg.value + div_quot;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_region = m_region_reg;

`ifndef SYNTH
    a_div_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");
    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> div_quot <= mag_reg)
        else $error("interpolation step exceeds segment rise");
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result beat raised outside the done state");
`endif

endmodule
`default_nettype wire
